/* hdl/crsc_pkg.sv */
`timescale 1ns / 1ps
package crsc_pkg;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_BOOT  = 2'd1,
		KIND_RESET = 2'd2,
		KIND_FAULT = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		TGT_PRI_COUNT = 3'd0,
		TGT_PRI_CHECK = 3'd1,
		TGT_BAK_COUNT = 3'd2,
		TGT_BAK_CHECK = 3'd3,
		TGT_IMP_COUNT = 3'd4,
		TGT_IMP_CHECK = 3'd5,
		TGT_IMB_COUNT = 3'd6,
		TGT_IMB_CHECK = 3'd7
	} target_t;

	typedef enum logic [2:0] {
		REC_PRIMARY = 3'd0,
		REC_BACKUP  = 3'd1,
		REC_SAVED_P = 3'd2,
		REC_SAVED_B = 3'd3,
		REC_ZEROED  = 3'd4,
		REC_NONE    = 3'd5
	} rec_t;

	typedef enum logic [2:0] {
		SRC_PRI,
		SRC_BAK,
		SRC_IMP,
		SRC_IMB,
		SRC_INC
	} src_t;

	typedef enum logic [2:0] {
		CM_NONE,
		CM_INC,
		CM_LOAD,
		CM_ZERO,
		CM_FAULT,
		CM_SAVE
	} commit_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_CHK_P,
		ST_CHK_B,
		ST_CHK_IP,
		ST_CHK_IB,
		ST_INC,
		ST_MOD_START,
		ST_MOD,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		REG_POLY   = 2'd0,
		REG_INIT   = 2'd1,
		REG_PERIOD = 2'd2
	} reg_idx_t;

	localparam int ADDR_W = 4;
	localparam logic [7:0] POLY_RESET = 8'd7;
	localparam logic [7:0] INIT_RESET = 8'd0;
	localparam logic [15:0] PERIOD_RESET = 16'd60;
	localparam logic [1:0] CRC_LAST = 2'd3;
	localparam logic [4:0] MOD_LAST = 5'd31;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  upset_target;
		logic [31:0] upset_mask;
	} item_t;

	typedef struct packed {
		logic [31:0] seconds;
		logic [7:0]  check_value;
		logic [2:0]  recovery;
		logic        saved;
	} result_t;

	typedef struct packed {
		logic [7:0]  crc_polynomial;
		logic [7:0]  crc_initial;
		logic [15:0] save_period;
	} cfg_t;

	typedef struct packed {
		logic    capture;
		logic    crc_start;
		src_t    crc_src;
		logic    mod_start;
		commit_t commit;
		logic    rec_wr;
		rec_t    rec_val;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  crc_busy;
		logic  crc_match;
		logic  mod_busy;
		logic  rem_zero;
		logic  period_zero;
	} dp_stat_t;

endpackage

/* hdl/crc_protected_redundant_second_counter.sv */
`timescale 1ns / 1ps
// Seconds counter held in a primary and a backup copy, each guarded by a CRC-8,
// with a saved image of both copies for recovery.
// Requests arrive on the item channel (valid/ready) and each produces exactly one
// result on the result channel (valid/ready), in order.
// A tick with a good primary copy runs two CRC passes (one byte per cycle),
// over the primary and over its incremented value, then a bit-serial modulo
// by the save period. A bad primary copy adds a pass over the backup; when
// both copies fail, the saved primary image and, if it fails, the saved
// backup image are checked in place of the increment pass; the loaded or
// zeroed value is not incremented. A zero save period skips the modulo.
// Only one request is in work at a time.
// The result sits in an output register; the next request is accepted while it
// waits, but a finished result waits for the register to drain when the
// receiver stalls.
// Reset clears all copies and images to zero and loads the configuration
// defaults (polynomial 7, initial value 0, save period 60). The user must write
// configuration on the APB port only while idle; the block does not enforce it.
module crc_protected_redundant_second_counter
	import crsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;
	state_t   state;
	logic     out_free;

	assign out_free = !result_valid || result_ready;

	crsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crsc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.out_free   (out_free),
		.stat       (stat),
		.cmd        (cmd),
		.state      (state)
	);

	crsc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("Result register loaded while a result is still pending.");

	a_crc_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.crc_start |-> !stat.crc_busy)
		else $error("CRC pass started while another is running.");

	a_mod_period: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mod_start |-> !stat.period_zero && state == ST_MOD_START)
		else $error("Modulo started with a zero save period.");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("Second request accepted while one is in work.");

endmodule

/* hdl/crsc_regs.sv */
`timescale 1ns / 1ps
module crsc_regs
	import crsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_polynomial <= POLY_RESET;
			cfg_q.crc_initial    <= INIT_RESET;
			cfg_q.save_period    <= PERIOD_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_POLY:   cfg_q.crc_polynomial <= pwdata[7:0];
				REG_INIT:   cfg_q.crc_initial    <= pwdata[7:0];
				REG_PERIOD: cfg_q.save_period    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_POLY:   prdata = {24'd0, cfg_q.crc_polynomial};
			REG_INIT:   prdata = {24'd0, cfg_q.crc_initial};
			REG_PERIOD: prdata = {16'd0, cfg_q.save_period};
			default:    prdata = 32'd0;
		endcase
	end

endmodule

/* hdl/crsc_dp.sv */
`timescale 1ns / 1ps
module crsc_dp
	import crsc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  item_t    item,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	input  logic     result_ready,
	output logic     result_valid,
	output result_t  result
);

	function automatic logic [7:0] crc_byte(input logic [7:0] c, input logic [7:0] d,
		input logic [7:0] p);
		logic [7:0] r;
		r = c ^ d;
		for (int k = 0; k < 8; k++) begin
			r = r[7] ? ({r[6:0], 1'b0} ^ p) : {r[6:0], 1'b0};
		end
		return r;
	endfunction

	item_t       item_q;
	logic [31:0] pri_cnt_q, bak_cnt_q, imp_cnt_q, imb_cnt_q;
	logic [7:0]  pri_chk_q, bak_chk_q, imp_chk_q, imb_chk_q;
	logic [31:0] w_q, sh_q, w_next;
	logic [7:0]  chk_q, chk_next, crc_q;
	logic [1:0]  crc_cnt_q;
	logic        crc_busy_q;
	logic [31:0] dvd_q;
	logic [15:0] rem_q;
	logic [16:0] rem_trial;
	logic [4:0]  mod_cnt_q;
	logic        mod_busy_q;
	rec_t        rec_q;
	logic        saved_q;
	logic        out_valid_q;
	result_t     out_q;

	always_comb begin
		case (cmd.crc_src)
			SRC_PRI: begin w_next = pri_cnt_q; chk_next = pri_chk_q; end
			SRC_BAK: begin w_next = bak_cnt_q; chk_next = bak_chk_q; end
			SRC_IMP: begin w_next = imp_cnt_q; chk_next = imp_chk_q; end
			SRC_IMB: begin w_next = imb_cnt_q; chk_next = imb_chk_q; end
			SRC_INC: begin w_next = w_q + 32'd1; chk_next = chk_q; end
			default: begin w_next = w_q; chk_next = chk_q; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_busy_q <= 1'b0;
			crc_cnt_q  <= 2'd0;
		end else if (cmd.crc_start) begin
			crc_busy_q <= 1'b1;
			crc_cnt_q  <= 2'd0;
		end else if (crc_busy_q) begin
			crc_cnt_q <= crc_cnt_q + 2'd1;
			if (crc_cnt_q == CRC_LAST) begin
				crc_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.crc_start) begin
			w_q   <= w_next;
			sh_q  <= w_next;
			chk_q <= chk_next;
			crc_q <= cfg.crc_initial;
		end else if (crc_busy_q) begin
			crc_q <= crc_byte(crc_q, sh_q[31:24], cfg.crc_polynomial);
			sh_q  <= {sh_q[23:0], 8'd0};
		end
	end

	assign rem_trial = {rem_q, dvd_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_busy_q <= 1'b0;
			mod_cnt_q  <= 5'd0;
		end else if (cmd.mod_start) begin
			mod_busy_q <= 1'b1;
			mod_cnt_q  <= 5'd0;
		end else if (mod_busy_q) begin
			mod_cnt_q <= mod_cnt_q + 5'd1;
			if (mod_cnt_q == MOD_LAST) begin
				mod_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_start) begin
			dvd_q <= pri_cnt_q;
			rem_q <= 16'd0;
		end else if (mod_busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (rem_trial >= {1'b0, cfg.save_period}) begin
				rem_q <= 16'(rem_trial - {1'b0, cfg.save_period});
			end else begin
				rem_q <= rem_trial[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pri_cnt_q <= 32'd0;
			pri_chk_q <= 8'd0;
			bak_cnt_q <= 32'd0;
			bak_chk_q <= 8'd0;
			imp_cnt_q <= 32'd0;
			imp_chk_q <= 8'd0;
			imb_cnt_q <= 32'd0;
			imb_chk_q <= 8'd0;
		end else begin
			case (cmd.commit)
				CM_INC: begin
					pri_cnt_q <= w_q;
					pri_chk_q <= crc_q;
					bak_cnt_q <= w_q;
					bak_chk_q <= crc_q;
				end
				CM_LOAD: begin
					pri_cnt_q <= w_q;
					pri_chk_q <= chk_q;
					bak_cnt_q <= w_q;
					bak_chk_q <= chk_q;
				end
				CM_ZERO: begin
					pri_cnt_q <= 32'd0;
					pri_chk_q <= 8'd0;
					bak_cnt_q <= 32'd0;
					bak_chk_q <= 8'd0;
				end
				CM_SAVE: begin
					imp_cnt_q <= pri_cnt_q;
					imp_chk_q <= pri_chk_q;
					imb_cnt_q <= bak_cnt_q;
					imb_chk_q <= bak_chk_q;
				end
				CM_FAULT: begin
					case (target_t'(item_q.upset_target))
						TGT_PRI_COUNT: pri_cnt_q <= pri_cnt_q ^ item_q.upset_mask;
						TGT_PRI_CHECK: pri_chk_q <= pri_chk_q ^ item_q.upset_mask[7:0];
						TGT_BAK_COUNT: bak_cnt_q <= bak_cnt_q ^ item_q.upset_mask;
						TGT_BAK_CHECK: bak_chk_q <= bak_chk_q ^ item_q.upset_mask[7:0];
						TGT_IMP_COUNT: imp_cnt_q <= imp_cnt_q ^ item_q.upset_mask;
						TGT_IMP_CHECK: imp_chk_q <= imp_chk_q ^ item_q.upset_mask[7:0];
						TGT_IMB_COUNT: imb_cnt_q <= imb_cnt_q ^ item_q.upset_mask;
						default:       imb_chk_q <= imb_chk_q ^ item_q.upset_mask[7:0];
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q   <= REC_NONE;
			saved_q <= 1'b0;
		end else begin
			if (cmd.rec_wr) begin
				rec_q <= cmd.rec_val;
			end
			if (cmd.capture) begin
				saved_q <= 1'b0;
			end else if (cmd.commit == CM_SAVE) begin
				saved_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.seconds     <= pri_cnt_q;
			out_q.check_value <= pri_chk_q;
			out_q.recovery    <= rec_q;
			out_q.saved       <= saved_q;
		end
	end

	assign result_valid     = out_valid_q;
	assign result           = out_q;
	assign stat.kind        = kind_t'(item_q.kind);
	assign stat.crc_busy    = crc_busy_q;
	assign stat.crc_match   = (crc_q == chk_q);
	assign stat.mod_busy    = mod_busy_q;
	assign stat.rem_zero    = (rem_q == 16'd0);
	assign stat.period_zero = (cfg.save_period == 16'd0);

endmodule

/* hdl/crsc_ctrl.sv */
`timescale 1ns / 1ps
module crsc_ctrl
	import crsc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  logic     out_free,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output state_t   state
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		item_ready    = 1'b0;
		cmd.capture   = 1'b0;
		cmd.crc_start = 1'b0;
		cmd.crc_src   = SRC_PRI;
		cmd.mod_start = 1'b0;
		cmd.commit    = CM_NONE;
		cmd.rec_wr    = 1'b0;
		cmd.rec_val   = REC_NONE;
		cmd.out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
				if (item_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (stat.kind)
					KIND_TICK: begin
						cmd.crc_start = 1'b1;
						cmd.crc_src   = SRC_PRI;
						state_d       = ST_CHK_P;
					end
					KIND_BOOT: begin
						cmd.crc_start = 1'b1;
						cmd.crc_src   = SRC_IMP;
						state_d       = ST_CHK_IP;
					end
					KIND_RESET: begin
						cmd.commit  = CM_ZERO;
						cmd.rec_wr  = 1'b1;
						cmd.rec_val = REC_ZEROED;
						state_d     = ST_DONE;
					end
					default: begin
						cmd.commit  = CM_FAULT;
						cmd.rec_wr  = 1'b1;
						cmd.rec_val = REC_NONE;
						state_d     = ST_DONE;
					end
				endcase
			end
			ST_CHK_P, ST_CHK_B: begin
				if (!stat.crc_busy) begin
					cmd.crc_start = 1'b1;
					if (stat.crc_match) begin
						cmd.crc_src = SRC_INC;
						cmd.rec_wr  = 1'b1;
						cmd.rec_val = (state_q == ST_CHK_P) ? REC_PRIMARY : REC_BACKUP;
						state_d     = ST_INC;
					end else if (state_q == ST_CHK_P) begin
						cmd.crc_src = SRC_BAK;
						state_d     = ST_CHK_B;
					end else begin
						cmd.crc_src = SRC_IMP;
						state_d     = ST_CHK_IP;
					end
				end
			end
			ST_CHK_IP: begin
				if (!stat.crc_busy) begin
					if (stat.crc_match) begin
						cmd.commit  = CM_LOAD;
						cmd.rec_wr  = 1'b1;
						cmd.rec_val = REC_SAVED_P;
						state_d     = (stat.kind == KIND_TICK) ? ST_MOD_START : ST_DONE;
					end else begin
						cmd.crc_start = 1'b1;
						cmd.crc_src   = SRC_IMB;
						state_d       = ST_CHK_IB;
					end
				end
			end
			ST_CHK_IB: begin
				if (!stat.crc_busy) begin
					cmd.rec_wr = 1'b1;
					if (stat.crc_match) begin
						cmd.commit  = CM_LOAD;
						cmd.rec_val = REC_SAVED_B;
					end else begin
						cmd.commit  = CM_ZERO;
						cmd.rec_val = REC_ZEROED;
					end
					state_d = (stat.kind == KIND_TICK) ? ST_MOD_START : ST_DONE;
				end
			end
			ST_INC: begin
				if (!stat.crc_busy) begin
					cmd.commit = CM_INC;
					state_d    = ST_MOD_START;
				end
			end
			ST_MOD_START: begin
				if (stat.period_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.mod_start = 1'b1;
					state_d       = ST_MOD;
				end
			end
			ST_MOD: begin
				if (!stat.mod_busy) begin
					if (stat.rem_zero) begin
						cmd.commit = CM_SAVE;
					end
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign state = state_q;

endmodule
